@@ rtl/pft_pkg.sv @@
// Package for the printf format tokenizer: token kinds, character codes,
// the burst record passed from decode to the emitter and the conversion lookup.
// Depends on nothing.
`default_nettype none

package pft_pkg;

   typedef enum logic [3:0] {
      KIND_LIT = 4'd0,
      KIND_D   = 4'd1,
      KIND_LD  = 4'd2,
      KIND_LLD = 4'd3,
      KIND_U   = 4'd4,
      KIND_LU  = 4'd5,
      KIND_LLU = 4'd6,
      KIND_X   = 4'd7,
      KIND_LX  = 4'd8,
      KIND_LLX = 4'd9,
      KIND_P   = 4'd10,
      KIND_F   = 4'd11,
      KIND_S   = 4'd12,
      KIND_C   = 4'd13,
      KIND_END = 4'd14
   } kind_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_L       = 8'h6C;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_P       = 8'h70;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_C       = 8'h63;

   localparam int MaxBurst = 4;

   // Up to four results caused by one request, in order.
   typedef struct packed {
      logic [2:0]                  count;
      kind_type [MaxBurst-1:0]     kind;
      logic [MaxBurst-1:0][7:0]    chr;
   } burst_type;

   // Conversion kind for byte c after (mode - 1) 'l' characters; KIND_LIT if none.
   function automatic kind_type conv_kind(input logic [1:0] mode, input logic [7:0] c);
      logic [3:0] ls;
      kind_type   k;
      ls = {2'b00, mode} - 4'd1;
      k  = KIND_LIT;
      if (c == CH_D || c == CH_I) begin
         k = kind_type'(4'(KIND_D) + ls);
      end else if (c == CH_U) begin
         k = kind_type'(4'(KIND_U) + ls);
      end else if (c == CH_X) begin
         k = kind_type'(4'(KIND_X) + ls);
      end else if (ls == 4'd0) begin
         case (c)
            CH_P:    k = KIND_P;
            CH_F:    k = KIND_F;
            CH_S:    k = KIND_S;
            CH_C:    k = KIND_C;
            default: k = KIND_LIT;
         endcase
      end
      return k;
   endfunction

endpackage

`default_nettype wire

@@ rtl/printf_format_tokenizer.sv @@
// Top level of the printf format tokenizer: prefix mode register, decode and
// burst emitter. Depends on pft_pkg, pft_decode and pft_emit.
//
// Usage: format bytes arrive on the req_ channel, one request per byte, with
// byte 0 ending a format. Tokens leave on the rsp_ channel as kind and
// char_value, with rsp_last marking the final token caused by a request.
// A request is taken at a rising edge where req_valid is high and req_stall
// is low; a token is taken likewise on the rsp_ side.
// A request that gives tokens shows its first token in the cycle after it is taken.
// Throughput: one request per unstalled cycle when each byte gives at most one token.
// A byte that gives k tokens (at most four) holds the emitter until the last
// one leaves, as the single result register shows one token per cycle while
// rsp_stall is low; the next request is taken in the cycle that last token leaves.
// A '%' or 'l' that only extends a pending prefix gives no token and never
// occupies the emitter.
// Reset clears the prefix mode and empties the result register. While the
// receiver stalls, the current token holds and req_stall rises once the
// emitter cannot take a new burst.
`default_nettype none

module printf_format_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_kind,
   output logic [7:0]       rsp_char_value,
   output logic             rsp_last
);
   import pft_pkg::*;

   // Pending prefix: 0 none, 1 "%", 2 "%l", 3 "%ll".
   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   burst_type  burst;
   logic       emit_ready;
   logic       accept;
   logic       load;

   pft_decode u_decode (
      .mode      (mode_ff),
      .ch        (req_ch),
      .burst     (burst),
      .next_mode (mode_in)
   );

   // A request is taken whenever the emitter is free or frees this cycle.
   assign req_stall = !emit_ready;
   assign accept    = req_valid && emit_ready;
   // Only requests that produce tokens load the emitter.
   assign load      = accept && (burst.count != 3'd0);

   pft_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .burst          (burst),
      .ready          (emit_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_char_value (rsp_char_value),
      .rsp_last       (rsp_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pft_decode.sv @@
// Decode logic of the format tokenizer: from the pending prefix and one byte,
// builds the result burst and the next prefix mode. Depends on pft_pkg.
`default_nettype none

module pft_decode (
   input  wire logic [1:0]        mode,
   input  wire logic [7:0]        ch,
   output pft_pkg::burst_type     burst,
   output logic [1:0]             next_mode
);
   import pft_pkg::*;

   logic     pct_pair;
   logic     l_extend;
   logic     conv_hit;
   logic     do_flush;
   logic     do_plain;
   kind_type conv;
   logic [2:0] n;

   always_comb begin
      conv     = (ch == CH_NUL) ? KIND_LIT : conv_kind(mode, ch);
      pct_pair = (mode == 2'd1) && (ch == CH_PERCENT);
      l_extend = (mode != 2'd0) && !pct_pair && (ch == CH_L) && (mode != 2'd3);
      conv_hit = (mode != 2'd0) && !pct_pair && !l_extend && (conv != KIND_LIT);
      do_flush = (mode != 2'd0) && !pct_pair && !l_extend && !conv_hit;
      do_plain = (mode == 2'd0) || do_flush;

      burst = '0;
      n     = 3'd0;
      if (pct_pair) begin
         burst.kind[n[1:0]] = KIND_LIT;
         burst.chr[n[1:0]]  = CH_PERCENT;
         n = n + 3'd1;
      end
      if (conv_hit) begin
         burst.kind[n[1:0]] = conv;
         n = n + 3'd1;
      end
      if (do_flush) begin
         burst.kind[n[1:0]] = KIND_LIT;
         burst.chr[n[1:0]]  = CH_PERCENT;
         n = n + 3'd1;
         if (mode != 2'd1) begin
            burst.kind[n[1:0]] = KIND_LIT;
            burst.chr[n[1:0]]  = CH_L;
            n = n + 3'd1;
         end
         if (mode == 2'd3) begin
            burst.kind[n[1:0]] = KIND_LIT;
            burst.chr[n[1:0]]  = CH_L;
            n = n + 3'd1;
         end
      end
      if (do_plain && ch != CH_PERCENT) begin
         if (ch == CH_NUL) begin
            burst.kind[n[1:0]] = KIND_END;
         end else begin
            burst.kind[n[1:0]] = KIND_LIT;
            burst.chr[n[1:0]]  = ch;
         end
         n = n + 3'd1;
      end
      burst.count = n;

      if (l_extend) begin
         next_mode = mode + 2'd1;
      end else if (do_plain && ch == CH_PERCENT) begin
         next_mode = 2'd1;
      end else begin
         next_mode = 2'd0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pft_emit.sv @@
// Result register and burst emitter of the format tokenizer: holds one burst
// and presents its entries one per cycle while rsp_stall is low. Depends on pft_pkg.
`default_nettype none

module pft_emit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire pft_pkg::burst_type burst,
   output logic                    ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_kind,
   output logic [7:0]              rsp_char_value,
   output logic                    rsp_last
);
   import pft_pkg::*;

   burst_type  buf_ff;
   logic [1:0] idx_ff;
   logic       valid_ff;
   logic       at_last;

   assign at_last        = ({1'b0, idx_ff} == (buf_ff.count - 3'd1));
   assign rsp_valid      = valid_ff;
   assign rsp_kind       = 4'(buf_ff.kind[idx_ff]);
   assign rsp_char_value = buf_ff.chr[idx_ff];
   assign rsp_last       = at_last;
   assign ready          = !valid_ff || (!rsp_stall && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (valid_ff && !rsp_stall) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= burst;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pft_checker.sv @@
// Port-level checker for the printf format tokenizer, bound to the top level.
// Depends on pft_pkg and printf_format_tokenizer.
`default_nettype none

module pft_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_ch,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_kind,
   input wire logic [7:0]  rsp_char_value,
   input wire logic        rsp_last
);
   import pft_pkg::*;

   // A stalled token stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // Only literal tokens carry a character.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != 4'(KIND_LIT) |-> rsp_char_value == 8'h00)
      else $error("non-literal token carries a character");

   // The end token is always the final token of its request.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 4'(KIND_END) |-> rsp_last)
      else $error("end token not marked last");

   // A taken end byte gives a token in the next cycle.
   a_end_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_ch == CH_NUL |=> rsp_valid)
      else $error("end byte produced no token");

   // Reset empties the result register.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token offered after reset");

endmodule

bind printf_format_tokenizer pft_checker u_pft_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_ch         (req_ch),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_char_value (rsp_char_value),
   .rsp_last       (rsp_last)
);

`default_nettype wire
